// ===== src/joystick_axis_conditioner_defines.svh =====
// Assertion macros shared by the conditioner's ring and framer modules.
`ifndef JOYSTICK_AXIS_CONDITIONER_DEFINES_SVH
`define JOYSTICK_AXIS_CONDITIONER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JAC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JAC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jac_pkg.sv =====
package jac_pkg;

    // Averaging window and sample format.
    localparam int WINDOW   = 5;
    localparam int SAMPLE_W = 12;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_MAX  = WINDOW * SAMPLE_MAX;
    localparam int SUM_W    = $clog2(SUM_MAX + 1);

    // Reciprocal for the divide by WINDOW; exact for every sum below 2**SUM_W.
    localparam int RECIP_K  = SUM_W + 5;
    localparam int RECIP_W  = RECIP_K + 1;
    localparam longint unsigned RECIP_M_L = ((64'd1 << RECIP_K) / WINDOW) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_M_L);
    localparam int QUO_W    = SUM_W + RECIP_W;

    // Centering and scaling to the output range.
    localparam logic [SAMPLE_W-1:0] CENTER = SAMPLE_W'(2048);
    localparam int FULL_OUT = 255;
    localparam int FULL_IN  = 2047;
    localparam int PROD_W   = 19;
    localparam int MAG_W    = 8;

    // Reciprocal for the divide by FULL_IN; exact for every product below 2**PROD_W.
    localparam int DIV_K    = 31;
    localparam int DIV_W    = 21;
    localparam longint unsigned DIV_M_L = ((64'd1 << DIV_K) / FULL_IN) + 64'd1;
    localparam logic [DIV_W-1:0] DIV_M = DIV_W'(DIV_M_L);
    localparam int SCALE_W  = PROD_W + DIV_W;

    // Axis codes.
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // Item after the ring stage.
    typedef struct packed {
        logic             axis;
        logic [SUM_W-1:0] sum;
    } ring_out_t;

    // Item after the scaling stages: sign and truncated magnitude.
    typedef struct packed {
        logic             axis;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } cond_out_t;

endpackage

// ===== src/jac_ring.sv =====
`include "joystick_axis_conditioner_defines.svh"

module jac_ring (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_axis_sel,
    input  logic [11:0]       s_sample,
    output logic              out_valid,
    input  logic              out_ready,
    output jac_pkg::ring_out_t out_data
);
    import jac_pkg::*;

    logic [SAMPLE_W-1:0] ring_x_reg [WINDOW];
    logic [SAMPLE_W-1:0] ring_y_reg [WINDOW];
    logic [POS_W-1:0]    pos_x_reg, pos_y_reg;
    logic [SUM_W-1:0]    sum_x_reg, sum_y_reg;
    logic [SUM_W-1:0]    sum_x_next, sum_y_next;
    logic                valid_reg;
    ring_out_t           data_reg;
    logic                accept;

    function automatic logic [POS_W-1:0] pos_step(input logic [POS_W-1:0] p);
        if (p >= POS_W'(WINDOW - 1)) begin
            return '0;
        end
        return p + POS_W'(1);
    endfunction

    assign s_ready   = !valid_reg || out_ready;
    assign accept    = s_valid && s_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // The running sum drops the oldest entry and adds the new request's sample.
    always_comb begin
        sum_x_next = sum_x_reg - SUM_W'(ring_x_reg[pos_x_reg]) + SUM_W'(s_sample);
        sum_y_next = sum_y_reg - SUM_W'(ring_y_reg[pos_y_reg]) + SUM_W'(s_sample);
    end

    // Ring storage, write positions and the stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring_x_reg[i] <= '0;
                ring_y_reg[i] <= '0;
            end
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (s_axis_sel == AXIS_X) begin
                    ring_x_reg[pos_x_reg] <= s_sample;
                    pos_x_reg             <= pos_step(pos_x_reg);
                    sum_x_reg             <= sum_x_next;
                    data_reg.sum          <= sum_x_next;
                end else begin
                    ring_y_reg[pos_y_reg] <= s_sample;
                    pos_y_reg             <= pos_step(pos_y_reg);
                    sum_y_reg             <= sum_y_next;
                    data_reg.sum          <= sum_y_next;
                end
                data_reg.axis <= s_axis_sel;
            end
            if (s_ready) begin
                valid_reg <= s_valid;
            end
        end
    end

    `JAC_ASSERT_NXT(a_pos_y_hold, aclk, aresetn, accept && (s_axis_sel == AXIS_X), $stable(pos_y_reg), "Y position moved on an X request")
    `JAC_ASSERT_NXT(a_stage_hold, aclk, aresetn, valid_reg && !out_ready, valid_reg && $stable(data_reg), "Ring stage changed while stalled")

endmodule

// ===== src/jac_cond.sv =====
module jac_cond (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  jac_pkg::ring_out_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output jac_pkg::cond_out_t out_data
);
    import jac_pkg::*;

    // Stage 1: average; stage 2: centered magnitude times FULL_OUT; stage 3: divide.
    logic                v1_reg, v2_reg, v3_reg;
    logic                rdy1, rdy2, rdy3;
    logic                axis1_reg, axis2_reg;
    logic [SAMPLE_W-1:0] avg1_reg;
    logic                neg2_reg;
    logic [PROD_W-1:0]   prod2_reg;
    cond_out_t           data3_reg;

    logic [QUO_W-1:0]    quo_full;
    logic [SAMPLE_W-1:0] avg_next;
    logic                neg_next;
    logic [SAMPLE_W-1:0] cmag;
    logic [PROD_W-1:0]   prod_next;
    logic [SCALE_W-1:0]  scale_full;

    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v3_reg;
    assign out_data  = data3_reg;

    // Integer average by reciprocal multiplication.
    always_comb begin
        quo_full = QUO_W'(in_data.sum) * QUO_W'(RECIP_M);
        avg_next = quo_full[RECIP_K +: SAMPLE_W];
    end

    // Center, then scale the magnitude by FULL_OUT as a shift and subtract.
    always_comb begin
        neg_next  = (avg1_reg < CENTER);
        cmag      = neg_next ? (CENTER - avg1_reg) : (avg1_reg - CENTER);
        prod_next = (PROD_W'(cmag) << 8) - PROD_W'(cmag);
    end

    // Divide the magnitude by FULL_IN; truncating the magnitude rounds toward zero.
    always_comb begin
        scale_full = SCALE_W'(prod2_reg) * SCALE_W'(DIV_M);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            axis1_reg <= in_data.axis;
            avg1_reg  <= avg_next;
        end
        if (rdy2 && v1_reg) begin
            axis2_reg <= axis1_reg;
            neg2_reg  <= neg_next;
            prod2_reg <= prod_next;
        end
        if (rdy3 && v2_reg) begin
            data3_reg.axis <= axis2_reg;
            data3_reg.neg  <= neg2_reg;
            data3_reg.mag  <= scale_full[DIV_K +: MAG_W];
        end
    end

endmodule

// ===== src/jac_framer.sv =====
`include "joystick_axis_conditioner_defines.svh"

module jac_framer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  jac_pkg::cond_out_t in_data,
    input  logic [7:0]         dead_zone,
    input  logic               x_invert,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last
);
    import jac_pkg::*;

    localparam logic [7:0] END_MARK = 8'hFF;
    localparam logic [1:0] LAST_POS = 2'd3;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        axis_reg;
    logic [15:0] value_reg;
    logic        neg_final;
    logic        nonzero;
    logic [15:0] value_next;
    logic        accept;
    logic        take_last;

    // Dead zone, inversion and the 16-bit two's-complement value.
    always_comb begin
        nonzero    = (in_data.mag != '0) && (in_data.mag >= dead_zone);
        neg_final  = in_data.neg ^ ((in_data.axis == AXIS_X) && x_invert);
        value_next = neg_final ? (16'd0 - 16'(in_data.mag)) : 16'(in_data.mag);
    end

    assign take_last = m_valid_reg && m_ready && (cnt_reg == LAST_POS);
    assign in_ready  = !m_valid_reg || take_last;
    assign accept    = in_valid && in_ready;

    // Byte sequencing: a zero result is taken and dropped.
    always_comb begin
        m_valid_next = m_valid_reg;
        cnt_next     = cnt_reg;
        if (m_valid_reg && m_ready) begin
            if (cnt_reg == LAST_POS) begin
                m_valid_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
        if (accept && nonzero) begin
            m_valid_next = 1'b1;
            cnt_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
        if (accept && nonzero) begin
            axis_reg  <= in_data.axis;
            value_reg <= value_next;
        end
    end

    // Output byte selection.
    always_comb begin
        case (cnt_reg)
            2'd0:    m_out_byte = {7'd0, axis_reg};
            2'd1:    m_out_byte = value_reg[7:0];
            2'd2:    m_out_byte = value_reg[15:8];
            default: m_out_byte = END_MARK;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_last  = (cnt_reg == LAST_POS);

    `JAC_ASSERT_NXT(a_frame_cont, aclk, aresetn, m_valid_reg && m_ready && (cnt_reg != LAST_POS), m_valid_reg, "Frame ended before its closing byte")
    `JAC_ASSERT_NXT(a_zero_drop, aclk, aresetn, !m_valid_reg && in_valid && !nonzero, !m_valid_reg, "Zero result started a frame")

endmodule

// ===== src/joystick_axis_conditioner.sv =====
// Joystick axis conditioner.
// Input requests carry an axis select (0 X, 1 Y) and a raw 12-bit sample on a
// valid/ready channel. Each request updates that axis's five-sample ring; the
// average is centered, scaled to -255..255, dead-zoned and, for X, optionally
// negated. A nonzero result leaves on the output channel as a four-byte frame:
// axis code, value low byte, value high byte, 0xFF (m_last set on 0xFF).
// A zero result produces no output.
// A request passes through registers in order: ring stage, average, scale
// product, divide, then the framer, which presents the first byte of a frame.
// Throughput: one request per cycle while results are zero and no frame is
// being sent; a frame holds the framer until its four bytes are taken, so the
// single-byte output port limits nonzero results.
// The configuration port writes dead_zone (index 0) and x_invert (index 1);
// write it only while no request is in flight.
// Reset clears both rings, their positions and all valid flags, and loads
// dead_zone 30 and x_invert 1. When the receiver stalls, the current byte
// holds and the pipeline fills, then s_ready drops.
module joystick_axis_conditioner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_axis_sel,
    input  logic [11:0] s_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import jac_pkg::*;

    localparam logic [3:0] CFG_DEAD_ZONE = 4'd0;
    localparam logic [3:0] CFG_X_INVERT  = 4'd1;

    logic [7:0] dead_zone_reg;
    logic       x_invert_reg;

    ring_out_t  ring_data;
    logic       ring_valid, ring_ready;
    cond_out_t  cond_data;
    logic       cond_valid, cond_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg <= 8'd30;
            x_invert_reg  <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEAD_ZONE: dead_zone_reg <= cfg_wdata;
                CFG_X_INVERT:  x_invert_reg  <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    jac_ring u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_axis_sel (s_axis_sel),
        .s_sample   (s_sample),
        .out_valid  (ring_valid),
        .out_ready  (ring_ready),
        .out_data   (ring_data)
    );

    jac_cond u_cond (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ring_valid),
        .in_ready  (ring_ready),
        .in_data   (ring_data),
        .out_valid (cond_valid),
        .out_ready (cond_ready),
        .out_data  (cond_data)
    );

    jac_framer u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (cond_valid),
        .in_ready   (cond_ready),
        .in_data    (cond_data),
        .dead_zone  (dead_zone_reg),
        .x_invert   (x_invert_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule

// ===== verif/joystick_axis_conditioner_tb.sv =====
`timescale 1ns / 100ps

module joystick_axis_conditioner_tb;
    import jac_pkg::*;

    localparam int        RING_DEPTH   = 5;
    localparam int        MID_CODE     = 2048;
    localparam int        OUT_SPAN     = 255;
    localparam int        IN_SPAN      = 2047;
    localparam logic [7:0] FRAME_END   = 8'hFF;
    localparam int        SAMPLE_TOP   = 4095;
    localparam int        DRAIN_CYCLES = 16;
    localparam int        LONG_HOLD    = 160;
    localparam int        MAX_REPORTS  = 10;

    // Configuration register indexes.
    localparam logic [3:0] REG_DEAD_ZONE = 4'd0;
    localparam logic [3:0] REG_X_INVERT  = 4'd1;
    localparam logic [3:0] REG_COUNT     = 4'd2;
    localparam logic [3:0] REG_LAST_IDX  = 4'd15;

    typedef struct {
        logic        axis;
        logic [11:0] sample;
    } axis_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_DENSE} rx_mode_t;

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic        s_axis_sel = 1'b0;
    logic [11:0] s_sample   = '0;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;
    logic        cfg_we     = 1'b0;
    logic [3:0]  cfg_index  = '0;
    logic [7:0]  cfg_wdata  = '0;

    joystick_axis_conditioner dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_axis_sel (s_axis_sel),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    // Shadow state of the conditioner: one sample ring and write position per axis.
    logic [11:0] sample_ring [0:1][0:RING_DEPTH-1];
    logic [2:0]  ring_pos [0:1];
    logic [7:0]  dead_zone_cfg = 8'd30;
    logic        x_invert_cfg  = 1'b1;

    axis_req_t   pending_reqs[$];
    frame_byte_t frame_bytes_due[$];

    logic req_taken       = 1'b0;
    int   mismatch_count  = 0;
    int   burst_left      = 0;
    int   gap_left        = 0;
    int   rx_pattern_left = 0;
    int   long_hold_left  = 0;
    logic long_hold_armed = 1'b0;
    rx_mode_t rx_mode     = RX_FREE;

    initial begin
        for (int a = 0; a < 2; a++) begin
            ring_pos[a] = '0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                sample_ring[a][i] = '0;
            end
        end
    end

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Push a sample into the axis ring and queue the frame bytes it should produce.
    task automatic predict_frame(input logic axis, input logic [11:0] smp);
        int          total;
        int          centered;
        int          scaled;
        int          mag;
        logic [15:0] word;
        sample_ring[axis][ring_pos[axis]] = smp;
        ring_pos[axis] = (ring_pos[axis] == RING_DEPTH - 1) ? 3'd0 : ring_pos[axis] + 3'd1;
        total = 0;
        for (int i = 0; i < RING_DEPTH; i++) begin
            total += int'(sample_ring[axis][i]);
        end
        centered = total / RING_DEPTH - MID_CODE;
        scaled   = (centered * OUT_SPAN) / IN_SPAN;
        mag      = (scaled < 0) ? -scaled : scaled;
        if (mag < dead_zone_cfg) begin
            scaled = 0;
        end
        if (axis == AXIS_X && x_invert_cfg) begin
            scaled = -scaled;
        end
        if (scaled != 0) begin
            word = scaled[15:0];
            frame_bytes_due.push_back('{data: {7'd0, axis}, last: 1'b0});
            frame_bytes_due.push_back('{data: word[7:0], last: 1'b0});
            frame_bytes_due.push_back('{data: word[15:8], last: 1'b0});
            frame_bytes_due.push_back('{data: FRAME_END, last: 1'b1});
        end
    endtask

    // Request driver: bursts of random length with random gaps in between.
    always @(negedge aclk) begin : drive_req
        axis_req_t req;
        logic      offer;
        if (aresetn && !(s_valid && !req_taken)) begin
            offer = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() != 0) begin
                req = pending_reqs.pop_front();
                s_axis_sel <= req.axis;
                s_sample   <= req.sample;
                offer = 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            s_valid <= offer;
        end
    end

    // Receiver: switches between stall patterns, plus one long hold-off when the stimulus arms it.
    always @(negedge aclk) begin : drive_ready
        logic take;
        if (long_hold_armed) begin
            long_hold_left  = LONG_HOLD;
            long_hold_armed = 1'b0;
        end
        if (rx_pattern_left == 0) begin
            rx_mode         = rx_mode_t'($urandom_range(0, 3));
            rx_pattern_left = $urandom_range(4, 40);
        end
        rx_pattern_left--;
        if (long_hold_left > 0) begin
            long_hold_left--;
            take = 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE:   take = 1'b1;
                RX_COIN:   take = 1'($urandom_range(0, 1));
                RX_SPARSE: take = ($urandom_range(0, 3) == 0);
                default:   take = ($urandom_range(0, 3) != 0);
            endcase
        end
        m_ready <= take;
    end

    // Monitor: predict on each accepted request, check each accepted frame byte.
    always @(posedge aclk) begin : watch_ports
        frame_byte_t want;
        req_taken = aresetn && s_valid && s_ready;
        if (req_taken) begin
            predict_frame(s_axis_sel, s_sample);
        end
        if (aresetn && m_valid && m_ready) begin
            if (frame_bytes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected frame byte %02h last %0b",
                             $realtime, m_out_byte, m_last);
                end
            end else begin
                want = frame_bytes_due.pop_front();
                if (m_out_byte !== want.data || m_last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                                 $realtime, want.data, want.last, m_out_byte, m_last);
                    end
                end
            end
        end
    end

    task automatic queue_req(input logic axis, input int smp);
        pending_reqs.push_back('{axis: axis, sample: smp[11:0]});
    endtask

    // Random requests, mostly runs that steer one axis's average toward a level.
    task automatic queue_random_reqs(input int count);
        int   queued;
        int   run_len;
        int   level;
        int   spread;
        int   smp;
        logic axis;
        queued = 0;
        while (queued < count) begin
            axis    = 1'($urandom_range(0, 1));
            run_len = $urandom_range(1, 7);
            case ($urandom_range(0, 4))
                0: begin
                    level  = ($urandom_range(0, 1) != 0) ? SAMPLE_TOP : 0;
                    spread = 0;
                end
                1: begin
                    level  = MID_CODE;
                    spread = 60;
                end
                2, 3: begin
                    level  = $urandom_range(0, SAMPLE_TOP);
                    spread = 15;
                end
                default: begin
                    level   = -1;
                    spread  = 0;
                    run_len = 1;
                end
            endcase
            for (int i = 0; i < run_len && queued < count; i++) begin
                if (level < 0) begin
                    smp = $urandom_range(0, SAMPLE_TOP);
                end else begin
                    smp = level + $urandom_range(0, 2 * spread) - spread;
                    if (smp < 0) smp = 0;
                    if (smp > SAMPLE_TOP) smp = SAMPLE_TOP;
                end
                queue_req(axis, smp);
                queued++;
            end
        end
    endtask

    // Return once every request is taken and every frame byte has come out.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || frame_bytes_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_DEAD_ZONE) begin
            dead_zone_cfg = value;
        end else if (idx == REG_X_INVERT) begin
            x_invert_cfg = value[0];
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: full-scale high on X (inverted), full-scale low on Y,
        // then Y pulled back to the center, where no frame comes out, and X partway.
        repeat (5) queue_req(AXIS_X, SAMPLE_TOP);
        repeat (5) queue_req(AXIS_Y, 0);
        repeat (5) queue_req(AXIS_Y, MID_CODE);
        queue_req(AXIS_X, MID_CODE);
        queue_req(AXIS_X, MID_CODE);
        wait_idle();

        // Dead zone of zero: the smallest nonzero value still makes a frame.
        // Extra high bits on the invert write and an unused index are dropped.
        write_reg(REG_DEAD_ZONE, 8'd0);
        write_reg(REG_X_INVERT, 8'hFE);
        write_reg(4'($urandom_range(REG_COUNT, REG_LAST_IDX)), 8'h5A);
        queue_req(AXIS_Y, MID_CODE + 45);
        queue_req(AXIS_Y, MID_CODE + 4);
        queue_req(AXIS_X, 0);
        queue_req(AXIS_X, SAMPLE_TOP);
        queue_req(AXIS_Y, MID_CODE - 45);
        wait_idle();

        // Random phases across a range of settings, extremes included.
        write_reg(REG_DEAD_ZONE, 8'($urandom_range(0, 255)));
        write_reg(REG_X_INVERT, 8'($urandom_range(0, 255)));
        queue_random_reqs(60);
        wait_idle();

        // Long receiver hold-off while requests keep coming, so the input stalls.
        write_reg(REG_DEAD_ZONE, 8'd0);
        write_reg(REG_X_INVERT, 8'h01);
        long_hold_armed = 1'b1;
        queue_random_reqs(60);
        wait_idle();

        write_reg(REG_DEAD_ZONE, 8'd255);
        write_reg(REG_X_INVERT, 8'h01);
        queue_random_reqs(60);
        wait_idle();

        write_reg(REG_DEAD_ZONE, 8'd1);
        write_reg(REG_X_INVERT, 8'h00);
        write_reg(4'($urandom_range(REG_COUNT, REG_LAST_IDX)), 8'($urandom_range(0, 255)));
        queue_random_reqs(60);
        wait_idle();

        write_reg(REG_DEAD_ZONE, 8'($urandom_range(0, 255)));
        write_reg(REG_X_INVERT, 8'($urandom_range(0, 255)));
        queue_random_reqs(60);
        wait_idle();

        write_reg(REG_DEAD_ZONE, 8'd30);
        write_reg(REG_X_INVERT, 8'h01);
        queue_random_reqs(60);
        wait_idle();

        if (frame_bytes_due.size() != 0) begin
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
